FILE: hdl/sebc_pkg.sv
// Shared types and constants for the STX/ETX frame receiver with block check.
package sebc_pkg;

    // Default frame buffer limit in bytes
    localparam int unsigned BUFFER_BYTES_DEFAULT = 64;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHECK_W = 7;
    localparam int unsigned LEN_W   = 7;

    // Block check keeps the low seven bits of the running XOR
    localparam logic [CHECK_W-1:0] CHECK_MASK = 7'h7f;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RESET   = 8'h03;

    // Receive phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_CHECK   = 3'b100
    } phase_t;

    // One result item
    typedef struct packed {
        logic               frame_done;
        logic               check_ok;
        logic [CHECK_W-1:0] computed_check;
        logic [BYTE_W-1:0]  received_check;
        logic [LEN_W-1:0]   frame_length;
        logic               overflow_abort;
    } sebc_result_t;

endpackage

FILE: hdl/stx_etx_frame_receiver_bcc_check_unit.sv
// Top level of the STX/ETX frame receiver with block check.
//
// Input channel: one received byte per item on rx_byte, handshake in_valid /
// in_stall. Output channel: one result item for every input item, handshake
// out_valid / out_stall, fields frame_done, check_ok, computed_check,
// received_check, frame_length and overflow_abort.
// Configuration: cfg_write with cfg_index 0 writes the start code, index 1
// the end code, from cfg_data; write only while no items are in flight.
// An item's result is computed combinationally and registered in the output
// register or skid stage. Throughput: one item per cycle while in_stall is
// low; the frame state (phase, byte count, running XOR) updates once per byte.
// Reset: frame state returns to hunting with count and XOR cleared, the
// start and end codes return to 0x02 and 0x03, and the output is empty.
// Stall: a held result stays in the output register; one more item is taken
// into a skid stage, after which in_stall rises until the output drains.
module stx_etx_frame_receiver_bcc_check_unit
    import sebc_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 frame_done,
    output logic                 check_ok,
    output logic [CHECK_W-1:0]   computed_check,
    output logic [BYTE_W-1:0]    received_check,
    output logic [LEN_W-1:0]     frame_length,
    output logic                 overflow_abort
);

    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic              buf_full;
    logic              in_accept;
    sebc_result_t      core_result;
    sebc_result_t      out_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RESET;
            end_code_reg   <= END_CODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_CODE: start_code_reg <= cfg_data;
                CFG_END_CODE:   end_code_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Take an item whenever the skid stage is free
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    sebc_frame_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_accept),
        .rx_byte    (rx_byte),
        .start_code (start_code_reg),
        .end_code   (end_code_reg),
        .result     (core_result)
    );

    sebc_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .load_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Unpack the result item onto the ports
    assign frame_done     = out_data.frame_done;
    assign check_ok       = out_data.check_ok;
    assign computed_check = out_data.computed_check;
    assign received_check = out_data.received_check;
    assign frame_length   = out_data.frame_length;
    assign overflow_abort = out_data.overflow_abort;

endmodule

FILE: hdl/sebc_frame_core.sv
// Frame tracking state and combinational result computation per received byte.
module sebc_frame_core
    import sebc_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_code,
    input  logic [BYTE_W-1:0] end_code,
    output sebc_result_t      result
);

    // Count reaches BUFFER_BYTES at most (on the check byte)
    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES - 2);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next, count_step;
    logic [BYTE_W-1:0]  xor_reg, xor_next, xor_step;
    logic [LEN_W-1:0]   length_view;
    logic               done;
    logic               abort_flag;
    logic [BYTE_W-1:0]  rcv;

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            xor_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    // Walk the frame: hunt, payload, check byte
    always_comb
    begin
        phase_next = phase_reg;
        count_step = count_reg;
        xor_step   = xor_reg;
        done       = 1'b0;
        abort_flag = 1'b0;
        rcv        = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == start_code)
                begin
                    count_step = CNT_ONE;
                    xor_step   = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (count_reg > CNT_LIMIT)
                begin
                    abort_flag = 1'b1;
                end
                else if (rx_byte == start_code)
                begin
                    count_step = CNT_ONE;
                    xor_step   = '0;
                end
                else
                begin
                    if (rx_byte == end_code)
                    begin
                        phase_next = PH_CHECK;
                    end
                    count_step = count_reg + CNT_ONE;
                    xor_step   = xor_reg ^ rx_byte;
                end
            end
            PH_CHECK:
            begin
                count_step = count_reg + CNT_ONE;
                done       = 1'b1;
                rcv        = rx_byte;
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_step = '0;
                xor_step   = '0;
            end
        endcase

        // Drop the frame after completion or abort
        if (done || abort_flag)
        begin
            phase_next = PH_HUNT;
            count_next = '0;
            xor_next   = '0;
        end
        else
        begin
            count_next = count_step;
            xor_next   = xor_step;
        end
    end

    // Show the low bits of the count
    generate
        if (CNT_W >= LEN_W)
        begin : g_len_cut
            assign length_view = count_step[LEN_W-1:0];
        end
        else
        begin : g_len_ext
            assign length_view = {{(LEN_W - CNT_W){1'b0}}, count_step};
        end
    endgenerate

    // Assemble the result item
    always_comb
    begin
        result.frame_done     = done;
        result.computed_check = xor_step[CHECK_W-1:0] & CHECK_MASK;
        result.received_check = rcv;
        result.check_ok       = done && (rcv == {1'b0, result.computed_check});
        result.frame_length   = length_view;
        result.overflow_abort = abort_flag;
    end

endmodule

FILE: hdl/sebc_out_buffer.sv
// Output register with a skid stage so input and output handshakes are decoupled.
module sebc_out_buffer
    import sebc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  sebc_result_t load_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output sebc_result_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    sebc_result_t out_data_reg, out_data_next;
    sebc_result_t skid_data_reg, skid_data_next;
    logic         out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Fill the output register first, park in the skid stage when it is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = load_data;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
